/* hdl/assert_macros.svh */
// Assertion macros shared by the verification checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed: expr");

// cons must hold in the cycle after ante, outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

// same as ASSERT_NEXT but also checked while reset is asserted
`define ASSERT_NEXT_ANY(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

`endif

/* hdl/iou_bms_pkg.sv */
// Shared types, constants and helpers for the IoU best-match selector
package iou_bms_pkg;

    localparam int MAX_PIXELS     = 1048576;
    localparam int MAX_CANDIDATES = 64;

    localparam int PIX_W  = 8;
    localparam int CNT_W  = 21;
    localparam int IDX_W  = 6;
    localparam int PROD_W = 2 * CNT_W;

    localparam logic [PIX_W-1:0] FG_VALUE = PIX_W'(255);

    localparam int CNT_FIELD_MAX = (2 ** CNT_W) - 1;
    localparam int CNT_CAP_INT   = (MAX_PIXELS < CNT_FIELD_MAX) ? MAX_PIXELS : CNT_FIELD_MAX;
    localparam int IDX_FIELD_MAX = (2 ** IDX_W) - 1;
    localparam int IDX_CAP_INT   = ((MAX_CANDIDATES - 1) < IDX_FIELD_MAX) ?
                                   (MAX_CANDIDATES - 1) : IDX_FIELD_MAX;

    typedef logic [CNT_W-1:0] t_count;
    typedef logic [IDX_W-1:0] t_idx;

    localparam t_count COUNT_CAP = CNT_W'(CNT_CAP_INT);
    localparam t_idx   IDX_CAP   = IDX_W'(IDX_CAP_INT);

    // one finished candidate, handed from the counter to the selector
    typedef struct packed {
        logic   valid;
        logic   last;
        t_idx   idx;
        t_count inter;
        t_count uni;
    } t_cand_done;

    function automatic t_count sat_inc(input t_count v);
        return (v < COUNT_CAP) ? v + t_count'(1) : v;
    endfunction

endpackage

/* hdl/iou_bms_accum.sv */
// Input register and per-candidate intersection/union counters
module iou_bms_accum (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [iou_bms_pkg::PIX_W-1:0]   i_query_pixel,
    input  logic [iou_bms_pkg::PIX_W-1:0]   i_candidate_pixel,
    input  logic                            i_end_of_image,
    input  logic                            i_end_of_candidates,
    output iou_bms_pkg::t_cand_done         o_done
);
    import iou_bms_pkg::*;

    logic       r_s1_valid;
    logic       r_s1_inter_hit;
    logic       r_s1_union_hit;
    logic       r_s1_eoi;
    logic       r_s1_eoc;

    t_count     r_inter;
    t_count     r_union;
    t_idx       r_idx;
    t_cand_done r_done;

    t_count     n_inter;
    t_count     n_union;

    logic       w_q_fg;
    logic       w_c_fg;

    assign w_q_fg = (i_query_pixel == FG_VALUE);
    assign w_c_fg = (i_candidate_pixel == FG_VALUE);

    always_comb begin
        n_inter = r_s1_inter_hit ? sat_inc(r_inter) : r_inter;
        n_union = r_s1_union_hit ? sat_inc(r_union) : r_union;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_inter      <= '0;
            r_union      <= '0;
            r_idx        <= '0;
            r_done.valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid     <= i_valid;
            r_s1_inter_hit <= w_q_fg && w_c_fg;
            r_s1_union_hit <= w_q_fg || w_c_fg;
            r_s1_eoi       <= i_end_of_image;
            // end of candidates only counts together with end of image
            r_s1_eoc       <= i_end_of_image && i_end_of_candidates;

            r_done.valid <= r_s1_valid && r_s1_eoi;
            r_done.last  <= r_s1_eoc;
            r_done.idx   <= r_idx;
            r_done.inter <= n_inter;
            r_done.uni   <= n_union;

            if (r_s1_valid) begin
                if (r_s1_eoi) begin
                    r_inter <= '0;
                    r_union <= '0;
                    if (r_s1_eoc) begin
                        r_idx <= '0;
                    end else if (r_idx < IDX_CAP) begin
                        r_idx <= r_idx + t_idx'(1);
                    end
                end else begin
                    r_inter <= n_inter;
                    r_union <= n_union;
                end
            end
        end
    end

    assign o_done = r_done;

endmodule

/* hdl/iou_bms_select.sv */
// Score compare by cross-multiplication, best-candidate tracking, result register
module iou_bms_select (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  iou_bms_pkg::t_cand_done         i_done,
    output logic                            o_valid,
    output logic [iou_bms_pkg::IDX_W-1:0]   o_best_candidate,
    output logic [iou_bms_pkg::CNT_W-1:0]   o_best_intersection,
    output logic [iou_bms_pkg::CNT_W-1:0]   o_best_union
);
    import iou_bms_pkg::*;

    logic               r_have_best;
    t_count             r_best_inter;
    t_count             r_best_uni;
    t_idx               r_best_idx;

    logic               r_out_valid;
    t_idx               r_out_idx;
    t_count             r_out_inter;
    t_count             r_out_uni;

    t_count             w_den_new;
    t_count             w_den_best;
    logic [PROD_W-1:0]  w_prod_new;
    logic [PROD_W-1:0]  w_prod_best;
    logic               w_win;

    // a zero union scores as 0/1
    assign w_den_new  = (i_done.uni == '0) ? t_count'(1) : i_done.uni;
    assign w_den_best = (r_best_uni == '0) ? t_count'(1) : r_best_uni;

    assign w_prod_new  = PROD_W'(i_done.inter) * PROD_W'(w_den_best);
    assign w_prod_best = PROD_W'(r_best_inter) * PROD_W'(w_den_new);

    assign w_win = !r_have_best || (w_prod_new > w_prod_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_best  <= 1'b0;
            r_best_inter <= '0;
            r_best_uni   <= '0;
            r_best_idx   <= '0;
            r_out_valid  <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= i_done.valid && i_done.last;
            if (i_done.valid) begin
                if (i_done.last) begin
                    r_out_idx    <= w_win ? i_done.idx   : r_best_idx;
                    r_out_inter  <= w_win ? i_done.inter : r_best_inter;
                    r_out_uni    <= w_win ? i_done.uni   : r_best_uni;
                    r_have_best  <= 1'b0;
                    r_best_inter <= '0;
                    r_best_uni   <= '0;
                    r_best_idx   <= '0;
                end else if (w_win) begin
                    r_have_best  <= 1'b1;
                    r_best_inter <= i_done.inter;
                    r_best_uni   <= i_done.uni;
                    r_best_idx   <= i_done.idx;
                end
            end
        end
    end

    assign o_valid             = r_out_valid;
    assign o_best_candidate    = r_out_idx;
    assign o_best_intersection = r_out_inter;
    assign o_best_union        = r_out_uni;

endmodule

/* hdl/iou_best_match_selector_top.sv */
// Three register stages (input register, per-candidate done register, result register);
// o_valid rises once the final pixel of the final candidate has passed through them.
// Throughput: one pixel pair per cycle; the pipeline holds only while a result is
// waiting in the output register and i_stall is high.
// Per cycle the last stage does one 21x21 cross-multiply pair and a 42-bit compare.
// Reset is synchronous, active low, and clears the running counts, the best match and o_valid.
module iou_best_match_selector_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [iou_bms_pkg::PIX_W-1:0]   i_query_pixel,
    input  logic [iou_bms_pkg::PIX_W-1:0]   i_candidate_pixel,
    input  logic                            i_end_of_image,
    input  logic                            i_end_of_candidates,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [iou_bms_pkg::IDX_W-1:0]   o_best_candidate,
    output logic [iou_bms_pkg::CNT_W-1:0]   o_best_intersection,
    output logic [iou_bms_pkg::CNT_W-1:0]   o_best_union
);
    import iou_bms_pkg::*;

    logic       w_en;
    t_cand_done w_done;

    // whole pipeline advances unless a finished result is being held
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    iou_bms_accum u_accum (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_en                (w_en),
        .i_valid             (i_valid),
        .i_query_pixel       (i_query_pixel),
        .i_candidate_pixel   (i_candidate_pixel),
        .i_end_of_image      (i_end_of_image),
        .i_end_of_candidates (i_end_of_candidates),
        .o_done              (w_done)
    );

    iou_bms_select u_select (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_en                (w_en),
        .i_done              (w_done),
        .o_valid             (o_valid),
        .o_best_candidate    (o_best_candidate),
        .o_best_intersection (o_best_intersection),
        .o_best_union        (o_best_union)
    );

endmodule

/* hdl/iou_bms_checker.sv */
// Port-level assertions for the IoU best-match selector, bound to the top level
`include "assert_macros.svh"

module iou_bms_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_stall,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [iou_bms_pkg::IDX_W-1:0]   o_best_candidate,
    input logic [iou_bms_pkg::CNT_W-1:0]   o_best_intersection,
    input logic [iou_bms_pkg::CNT_W-1:0]   o_best_union
);
    import iou_bms_pkg::*;

    // a held result keeps its payload
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_best_candidate) && $stable(o_best_intersection) && $stable(o_best_union))

    // intersection never exceeds union, and counts do not exceed the saturation cap
    `ASSERT_ALWAYS(a_counts_sane, i_clk, i_rst_n, !o_valid || ((o_best_intersection <= o_best_union) && (o_best_union <= COUNT_CAP)))

    // input side only stalls behind a waiting result
    `ASSERT_ALWAYS(a_stall_cause, i_clk, i_rst_n, o_stall == (o_valid && i_stall))

    // reset leaves no result pending
    `ASSERT_NEXT_ANY(a_reset_clear, i_clk, !i_rst_n, !o_valid)

endmodule

bind iou_best_match_selector_top iou_bms_checker u_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_stall             (o_stall),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_best_candidate    (o_best_candidate),
    .o_best_intersection (o_best_intersection),
    .o_best_union        (o_best_union)
);

/* tb/sv/tb_top.sv */
// Self-checking testbench for the IoU best-match selector top level
`timescale 1ns / 1ps

module tb_top;
    import iou_bms_pkg::*;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        t_idx   cand;
        t_count inter;
        t_count uni;
    } t_match;

    // one directed row: a pixel pair repeated reps times, optionally with a known outcome
    typedef struct packed {
        t_pix        q;
        t_pix        c;
        logic        eoi;
        logic        eoc;
        logic [31:0] reps;
        logic        chk;
        t_match      want;
    } t_px_row;

    localparam int N_ROWS          = 16;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int TAIL_CYCLES     = 10;
    localparam int PHASE_PIXELS    = 250;
    localparam int SEND_IDLE [4]   = '{0, 68, 0, 32};
    localparam int RECV_STALL [4]  = '{0, 0, 68, 32};

    localparam t_px_row DIRECTED_ROWS [N_ROWS] = '{
        // plain query, one candidate; end_of_candidates alone is ignored
        '{8'd255, 8'd255, 1'b0, 1'b0, 32'd1, 1'b0, '{6'd0, 21'd0, 21'd0}},
        '{8'd255, 8'd0,   1'b0, 1'b1, 32'd1, 1'b0, '{6'd0, 21'd0, 21'd0}},
        '{8'd0,   8'd255, 1'b0, 1'b0, 32'd1, 1'b0, '{6'd0, 21'd0, 21'd0}},
        '{8'd0,   8'd0,   1'b1, 1'b1, 32'd1, 1'b1, '{6'd0, 21'd1, 21'd3}},
        // empty union, then a perfect match, then a tie that keeps the earlier one
        '{8'd254, 8'd254, 1'b1, 1'b0, 32'd1, 1'b0, '{6'd0, 21'd0, 21'd0}},
        '{8'd255, 8'd255, 1'b1, 1'b0, 32'd1, 1'b0, '{6'd0, 21'd0, 21'd0}},
        '{8'd255, 8'd255, 1'b1, 1'b1, 32'd1, 1'b1, '{6'd1, 21'd1, 21'd1}},
        // zero scores tie, first candidate stays
        '{8'd0,   8'd0,   1'b1, 1'b0, 32'd1, 1'b0, '{6'd0, 21'd0, 21'd0}},
        '{8'd255, 8'd0,   1'b1, 1'b1, 32'd1, 1'b1, '{6'd0, 21'd0, 21'd0}},
        // more candidates than the index can count
        '{8'd255, 8'd0,   1'b1, 1'b0, 32'd69, 1'b0, '{6'd0, 21'd0, 21'd0}},
        '{8'd255, 8'd255, 1'b1, 1'b1, 32'd1, 1'b1, '{6'd63, 21'd1, 21'd1}},
        // 1/2 beaten by 2/3
        '{8'd128, 8'd255, 1'b0, 1'b0, 32'd1, 1'b0, '{6'd0, 21'd0, 21'd0}},
        '{8'd255, 8'd255, 1'b1, 1'b0, 32'd1, 1'b0, '{6'd0, 21'd0, 21'd0}},
        '{8'd255, 8'd1,   1'b0, 1'b0, 32'd1, 1'b0, '{6'd0, 21'd0, 21'd0}},
        '{8'd255, 8'd255, 1'b0, 1'b0, 32'd2, 1'b0, '{6'd0, 21'd0, 21'd0}},
        '{8'd0,   8'd0,   1'b1, 1'b1, 32'd1, 1'b1, '{6'd1, 21'd2, 21'd3}}
    };

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_stall;
    t_pix   i_query_pixel;
    t_pix   i_candidate_pixel;
    logic   i_end_of_image;
    logic   i_end_of_candidates;
    logic   o_valid;
    logic   i_stall;
    t_idx   o_best_candidate;
    t_count o_best_intersection;
    t_count o_best_union;

    // predictor state
    t_count cur_inter = '0;
    t_count cur_union = '0;
    t_count top_inter = '0;
    t_count top_union = '0;
    t_idx   top_idx   = '0;
    t_idx   cand_idx  = '0;
    logic   have_top  = 1'b0;
    t_match last_prediction;

    t_match      expected_matches [$];
    int          mismatches    = 0;
    int          pixels_sent   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    logic        long_hold     = 1'b0;

    iou_best_match_selector_top DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_query_pixel       (i_query_pixel),
        .i_candidate_pixel   (i_candidate_pixel),
        .i_end_of_image      (i_end_of_image),
        .i_end_of_candidates (i_end_of_candidates),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_best_candidate    (o_best_candidate),
        .o_best_intersection (o_best_intersection),
        .o_best_union        (o_best_union)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // IoU scoring of one accepted pixel pair; queues the best match at the final candidate
    task automatic track_best_match(input t_pix q, input t_pix c, input logic eoi,
                                    input logic eoc);
        logic              q_fg;
        logic              c_fg;
        t_count            cur_den;
        t_count            top_den;
        logic [PROD_W-1:0] cur_cross;
        logic [PROD_W-1:0] top_cross;
        q_fg = (q == FG_VALUE);
        c_fg = (c == FG_VALUE);
        if (q_fg && c_fg && cur_inter < COUNT_CAP) cur_inter++;
        if ((q_fg || c_fg) && cur_union < COUNT_CAP) cur_union++;
        if (eoi) begin
            // empty union scores 0/1
            cur_den   = (cur_union == '0) ? t_count'(1) : cur_union;
            top_den   = (top_union == '0) ? t_count'(1) : top_union;
            cur_cross = PROD_W'(cur_inter) * PROD_W'(top_den);
            top_cross = PROD_W'(top_inter) * PROD_W'(cur_den);
            if (!have_top || cur_cross > top_cross) begin
                top_inter = cur_inter;
                top_union = cur_union;
                top_idx   = cand_idx;
                have_top  = 1'b1;
            end
            cur_inter = '0;
            cur_union = '0;
            if (!eoc) begin
                if (cand_idx < IDX_CAP) cand_idx++;
            end else begin
                last_prediction = '{cand: top_idx, inter: top_inter, uni: top_union};
                expected_matches = {expected_matches, last_prediction};
                top_inter = '0;
                top_union = '0;
                top_idx   = '0;
                cand_idx  = '0;
                have_top  = 1'b0;
            end
        end
    endtask

    function automatic void compare_match(string src, t_match want, t_match got);
        if (got.cand !== want.cand) begin
            $error("%s best_candidate: expected %0d, got %0d", src, want.cand, got.cand);
            mismatches++;
        end
        if (got.inter !== want.inter) begin
            $error("%s best_intersection: expected %0d, got %0d", src, want.inter, got.inter);
            mismatches++;
        end
        if (got.uni !== want.uni) begin
            $error("%s best_union: expected %0d, got %0d", src, want.uni, got.uni);
            mismatches++;
        end
    endfunction

    function automatic t_pix rand_pixel();
        case ($urandom_range(3))
            0, 1: return FG_VALUE;
            2: return '0;
            default: return t_pix'($urandom_range(255));
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after the request is taken
    task automatic drive_pixel(input t_pix q, input t_pix c, input logic eoi,
                               input logic eoc);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid             = 1'b1;
        i_query_pixel       = q;
        i_candidate_pixel   = c;
        i_end_of_image      = eoi;
        i_end_of_candidates = eoc;
        do @(posedge i_clk); while (o_stall);
        track_best_match(q, c, eoi, eoc);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic random_query();
        int   n_cand;
        int   max_pix;
        int   n_pix;
        logic last_pix;
        if ($urandom_range(29) == 0) begin
            n_cand  = $urandom_range(72, 40);
            max_pix = 2;
        end else begin
            n_cand  = $urandom_range(6, 1);
            max_pix = 8;
        end
        for (int k = 0; k < n_cand; k++) begin
            n_pix = $urandom_range(max_pix, 1);
            for (int p = 0; p < n_pix; p++) begin
                last_pix = (p == n_pix - 1);
                // stray end_of_candidates on inner pixels
                drive_pixel(rand_pixel(), rand_pixel(), last_pix,
                            last_pix ? (k == n_cand - 1) : ($urandom_range(5) == 0));
            end
        end
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (expected_matches.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int phase_start;
        i_rst_n             = 1'b0;
        i_valid             = 1'b0;
        i_query_pixel       = '0;
        i_candidate_pixel   = '0;
        i_end_of_image      = 1'b0;
        i_end_of_candidates = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            repeat (DIRECTED_ROWS[r].reps)
                drive_pixel(DIRECTED_ROWS[r].q, DIRECTED_ROWS[r].c,
                            DIRECTED_ROWS[r].eoi, DIRECTED_ROWS[r].eoc);
            if (DIRECTED_ROWS[r].chk)
                compare_match($sformatf("row %0d", r), DIRECTED_ROWS[r].want, last_prediction);
        end
        drain();

        // receiver holds off while single-pixel queries keep coming
        long_hold = 1'b1;
        repeat (40) drive_pixel(FG_VALUE, t_pix'($urandom_range(255)), 1'b1, 1'b1);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = SEND_IDLE[ph];
            stall_pct     = RECV_STALL[ph];
            phase_start   = pixels_sent;
            while (pixels_sent - phase_start < PHASE_PIXELS) random_query();
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_matches.size() == 0)
            $display("iou_best_match_selector_top test passed");
        else
            $display("iou_best_match_selector_top test failed");
        $finish;
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                long_hold = 1'b0;
            end
            i_stall = ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_matches.size() == 0) begin
                $error("unexpected result: best_candidate %0d, best_intersection %0d",
                       o_best_candidate, o_best_intersection);
                mismatches++;
            end else begin
                compare_match("result", expected_matches.pop_front(),
                              {o_best_candidate, o_best_intersection, o_best_union});
            end
        end
    end

    // ends the run when neither side has moved a request for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("iou_best_match_selector_top test failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/iou_bms_pkg.sv
hdl/iou_bms_accum.sv
hdl/iou_bms_select.sv
hdl/iou_best_match_selector_top.sv
hdl/iou_bms_checker.sv
tb/sv/tb_top.sv
